// ----- src/ptts_pkg.sv -----
// ----------------------------------------------------------------------------
// ptts_pkg
// types and constants shared by the tick scheduler cells and its top level
// ----------------------------------------------------------------------------
package ptts_pkg;

    // command codes
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_CREATE   = 3'd1;
    localparam logic [2:0] CMD_STOP     = 3'd2;
    localparam logic [2:0] CMD_RESUME   = 3'd3;
    localparam logic [2:0] CMD_DISPATCH = 3'd4;

    // result kinds and create status codes
    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_RUN     = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    // at most this many runs reported per dispatch
    localparam int MAX_EMIT = 8;
    localparam int COUNT_W  = 4;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  task_index;
        logic [15:0] initial_delay;
        logic [15:0] period;
        logic        has_handler;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [2:0] run_index;
        logic       status;
        logic       last;
    } out_item_t;

    // what passes from one cell to the next each cycle
    typedef struct packed {
        logic               here;
        logic [COUNT_W-1:0] count;
    } wave_t;

endpackage

// ----- src/periodic_task_tick_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_unit
// cooperative tick scheduler: a row of task slot cells swept by a command wave
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. It is then passed
// down the row of slot cells, one cell per clock, and busy stays high while
// the command is in the row, so the next command can be taken only once the
// wave has left the last cell; this is set by the length of the cell row.
// Results leave through an output register: a create status passes through
// the create flag register and then the output register, and a dispatch
// reports its pending slots lowest index first, at most eight per dispatch,
// each as the wave passes its cell, with last set on the final one. Each result
// is shown for a single cycle with result_valid and cannot be held off by
// the receiver. Tick, stop, resume and unknown commands give no result.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_unit #(
    parameter int TASK_SLOTS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ptts_pkg::in_item_t  item,
    output logic                result_valid,
    output ptts_pkg::out_item_t result
);

    // command held for the whole sweep
    ptts_pkg::in_item_t  item_reg;
    logic                go;
    logic                create_reg;
    logic                create_ok_reg;

    // the row of cells and their taps
    ptts_pkg::wave_t     wave_in  [TASK_SLOTS];
    ptts_pkg::wave_t     wave_out [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] here_vec;
    logic [TASK_SLOTS-1:0] pend_vec;
    logic [TASK_SLOTS-1:0] later_vec;
    logic [TASK_SLOTS-1:0] emit_vec;
    logic [TASK_SLOTS-1:0] last_vec;

    // output register
    logic                result_valid_reg, result_valid_next;
    ptts_pkg::out_item_t result_reg, result_next;

    assign busy = |here_vec;
    assign go   = start & ~busy;

    genvar k;
    generate
        for (k = 0; k < TASK_SLOTS; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                // the head cell is fed by the transfer itself
                assign wave_in[k].here  = go;
                assign wave_in[k].count = '0;
            end
            else
            begin : g_link
                assign wave_in[k] = wave_out[k-1];
            end

            // any slot further down still waiting to run
            if (k == TASK_SLOTS - 1)
            begin : g_tail
                assign later_vec[k] = 1'b0;
            end
            else
            begin : g_body
                assign later_vec[k] = |pend_vec[TASK_SLOTS-1:k+1];
            end

            assign here_vec[k] = wave_out[k].here;

            ptts_cell #(
                .SLOT (k)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .wave_in   (wave_in[k]),
                .item      (item_reg),
                .later_any (later_vec[k]),
                .wave_out  (wave_out[k]),
                .pend_flag (pend_vec[k]),
                .emit      (emit_vec[k]),
                .emit_last (last_vec[k])
            );
        end
    endgenerate

    // select the single emitting cell, or the create status
    always_comb
    begin
        result_valid_next = 1'b0;
        result_next       = '0;
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            if (emit_vec[i])
            begin
                result_valid_next   = 1'b1;
                result_next.kind    = ptts_pkg::KIND_RUN;
                result_next.run_index = 3'(i);
                result_next.status  = ptts_pkg::STATUS_OK;
                result_next.last    = last_vec[i];
            end
        end
        if (create_reg)
        begin
            result_valid_next     = 1'b1;
            result_next.kind      = ptts_pkg::KIND_STATUS;
            result_next.run_index = 3'd0;
            result_next.status    = create_ok_reg ? ptts_pkg::STATUS_OK
                                                  : ptts_pkg::STATUS_ERROR;
            result_next.last      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            create_reg       <= 1'b0;
            create_ok_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            create_reg       <= go && (item.command == ptts_pkg::CMD_CREATE);
            create_ok_reg    <= item.has_handler &&
                                (item.task_index < 8'(TASK_SLOTS));
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (go)
            item_reg <= item;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // the wave sits in at most one cell at a time
    a_one_wave: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(here_vec))
        else $error("command wave in more than one cell");

    // a transfer always starts a sweep
    a_sweep_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> here_vec[0])
        else $error("transfer did not enter the head cell");

    // at most one cell reports a run per cycle
    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(emit_vec))
        else $error("two cells report a run together");

    // a create status is always the only and final result
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == ptts_pkg::KIND_STATUS) |-> result.last)
        else $error("create status without last");

    // run reports only come out of a sweep
    a_run_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == ptts_pkg::KIND_RUN) |-> $past(busy))
        else $error("run reported outside a sweep");

endmodule

// ----- src/ptts_cell.sv -----
// ----------------------------------------------------------------------------
// ptts_cell
// one task slot; acts on the current command when the wave reaches it
// ----------------------------------------------------------------------------
module ptts_cell #(
    parameter int SLOT = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ptts_pkg::wave_t   wave_in,
    input  ptts_pkg::in_item_t item,
    input  logic              later_any,
    output ptts_pkg::wave_t   wave_out,
    output logic              pend_flag,
    output logic              emit,
    output logic              emit_last
);

    logic                         here_reg;
    logic [ptts_pkg::COUNT_W-1:0] count_reg;
    logic                         registered_reg, registered_next;
    logic                         active_reg, active_next;
    logic                         pending_reg, pending_next;
    logic [15:0]                  countdown_reg, countdown_next;
    logic [15:0]                  period_reg, period_next;
    logic                         match;

    assign match     = (item.task_index == 8'(SLOT));
    assign pend_flag = registered_reg & pending_reg;

    always_comb
    begin
        registered_next = registered_reg;
        active_next     = active_reg;
        pending_next    = pending_reg;
        countdown_next  = countdown_reg;
        period_next     = period_reg;
        emit            = 1'b0;
        emit_last       = 1'b0;
        if (here_reg)
        begin
            case (item.command)
                ptts_pkg::CMD_TICK:
                begin
                    if (registered_reg && active_reg)
                    begin
                        if (countdown_reg == 16'd0)
                        begin
                            pending_next   = 1'b1;
                            countdown_next = period_reg - 16'd1;
                        end
                        else
                        begin
                            countdown_next = countdown_reg - 16'd1;
                        end
                    end
                end
                ptts_pkg::CMD_CREATE:
                begin
                    if (match && item.has_handler)
                    begin
                        registered_next = 1'b1;
                        active_next     = 1'b1;
                        countdown_next  = item.initial_delay;
                        period_next     = item.period;
                    end
                end
                ptts_pkg::CMD_STOP, ptts_pkg::CMD_RESUME:
                begin
                    if (match && registered_reg)
                        active_next = (item.command == ptts_pkg::CMD_RESUME);
                end
                ptts_pkg::CMD_DISPATCH:
                begin
                    if (pend_flag && (count_reg < ptts_pkg::COUNT_W'(ptts_pkg::MAX_EMIT)))
                    begin
                        pending_next = 1'b0;
                        emit         = 1'b1;
                        emit_last    = ~later_any ||
                            (count_reg == ptts_pkg::COUNT_W'(ptts_pkg::MAX_EMIT - 1));
                    end
                end
                default:
                begin
                end
            endcase
        end
        wave_out.here  = here_reg;
        wave_out.count = count_reg + ptts_pkg::COUNT_W'(emit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            here_reg       <= 1'b0;
            count_reg      <= '0;
            registered_reg <= 1'b0;
            active_reg     <= 1'b0;
            pending_reg    <= 1'b0;
            countdown_reg  <= '0;
            period_reg     <= '0;
        end
        else
        begin
            here_reg       <= wave_in.here;
            count_reg      <= wave_in.count;
            registered_reg <= registered_next;
            active_reg     <= active_next;
            pending_reg    <= pending_next;
            countdown_reg  <= countdown_next;
            period_reg     <= period_next;
        end
    end

endmodule

// ----- tb/tick_scheduler_checker.sv -----
// ----------------------------------------------------------------------------
// tick_scheduler_checker
// watches the command and result channels of the tick scheduler, predicts
// every result and compares it field by field with what the block emits
// ----------------------------------------------------------------------------
module tick_scheduler_checker #(
    parameter int TASK_SLOTS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  ptts_pkg::in_item_t  item,
    input  logic                result_valid,
    input  ptts_pkg::out_item_t result,
    output int                  error_count,
    output int                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // predicted slot table
    logic        enrolled  [TASK_SLOTS];
    logic        running   [TASK_SLOTS];
    logic [15:0] ticks_left[TASK_SLOTS];
    logic [15:0] reload    [TASK_SLOTS];
    logic        due       [TASK_SLOTS];

    ptts_pkg::out_item_t awaited_results[$];
    ptts_pkg::out_item_t oldest;
    int                  errors;

    function automatic int field_diff(string field, int want, int got);
        if (want == got)
            return 0;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        return 1;
    endfunction

    // advance the slot table by one command and queue the results it causes
    task automatic step_scheduler(input ptts_pkg::in_item_t cmd);
        ptts_pkg::out_item_t runs[TASK_SLOTS];
        ptts_pkg::out_item_t reply;
        int                  emitted;
        int                  slot;
        logic                in_range;
        emitted  = 0;
        slot     = cmd.task_index;
        in_range = cmd.task_index < TASK_SLOTS;
        case (cmd.command)
            ptts_pkg::CMD_TICK:
                for (int s = 0; s < TASK_SLOTS; s++)
                begin
                    if (enrolled[s] && running[s])
                    begin
                        if (ticks_left[s] == 16'd0)
                        begin
                            due[s]        = 1'b1;
                            ticks_left[s] = reload[s] - 16'd1;
                        end
                        else
                            ticks_left[s] = ticks_left[s] - 16'd1;
                    end
                end
            ptts_pkg::CMD_CREATE:
            begin
                reply.kind      = ptts_pkg::KIND_STATUS;
                reply.run_index = '0;
                reply.last      = 1'b1;
                if (in_range && cmd.has_handler)
                begin
                    reload[slot]     = cmd.period;
                    ticks_left[slot] = cmd.initial_delay;
                    enrolled[slot]   = 1'b1;
                    running[slot]    = 1'b1;
                    reply.status     = ptts_pkg::STATUS_OK;
                end
                else
                    reply.status = ptts_pkg::STATUS_ERROR;
                awaited_results.push_back(reply);
            end
            ptts_pkg::CMD_STOP, ptts_pkg::CMD_RESUME:
                if (in_range && enrolled[slot])
                    running[slot] = (cmd.command == ptts_pkg::CMD_RESUME);
            ptts_pkg::CMD_DISPATCH:
            begin
                for (int s = 0; s < TASK_SLOTS; s++)
                begin
                    if (enrolled[s] && due[s] && emitted < ptts_pkg::MAX_EMIT)
                    begin
                        due[s]                   = 1'b0;
                        runs[emitted].kind      = ptts_pkg::KIND_RUN;
                        runs[emitted].run_index = 3'(s);
                        runs[emitted].status    = ptts_pkg::STATUS_OK;
                        runs[emitted].last      = 1'b0;
                        emitted++;
                    end
                end
                for (int k = 0; k < emitted; k++)
                begin
                    reply      = runs[k];
                    reply.last = (k == emitted - 1);
                    awaited_results.push_back(reply);
                end
            end
            default:
                ;
        endcase
    endtask

    // results are compared before a new command is predicted, since a result
    // seen at an edge always belongs to an earlier transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < TASK_SLOTS; s++)
            begin
                enrolled[s]   = 1'b0;
                running[s]    = 1'b0;
                ticks_left[s] = '0;
                reload[s]     = '0;
                due[s]        = 1'b0;
            end
            awaited_results.delete();
            errors = 0;
            error_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result with none expected, expected none, actual %p",
                             $time, result);
                    errors++;
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    errors += field_diff("kind", oldest.kind, result.kind);
                    errors += field_diff("run_index", oldest.run_index, result.run_index);
                    errors += field_diff("status", oldest.status, result.status);
                    errors += field_diff("last", oldest.last, result.last);
                end
            end
            if (start && !busy)
                step_scheduler(item);
            error_count <= errors;
            outstanding <= awaited_results.size();
        end
    end

endmodule

// ----- tb/periodic_task_tick_scheduler_unit_tb.sv -----
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_unit_tb
// regression for the cooperative tick scheduler: a directed opening that
// covers creates, stop and resume, zero periods, full tables and recreates,
// then random command streams with bursty pacing; all results are checked
// by a separate checker module
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TASK_SLOTS   = 8;
    localparam int RANDOM_ITEMS = 280;
    // worst case is 311 transfers, each with its gap and sweep, far below this
    localparam int CYCLE_LIMIT  = 60000;
    // a dispatch may still be emitting for a full sweep after its transfer
    localparam int DRAIN_CYCLES = 2 * TASK_SLOTS + 4;

    logic                clk   = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    ptts_pkg::in_item_t  item  = '0;
    logic                result_valid;
    ptts_pkg::out_item_t result;

    int mismatch_count;
    int results_owed;
    int cycle_count = 0;
    int burst_left  = 0;

    periodic_task_tick_scheduler_unit #(
        .TASK_SLOTS(TASK_SLOTS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .result_valid(result_valid),
        .result      (result)
    );

    tick_scheduler_checker #(
        .TASK_SLOTS(TASK_SLOTS)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .result_valid(result_valid),
        .result      (result),
        .error_count (mismatch_count),
        .outstanding (results_owed)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: a hung handshake or missing result ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("periodic_task_tick_scheduler_unit regression: fail");
            $finish;
        end
    end

    function automatic ptts_pkg::in_item_t pack_command(logic [2:0] cmd, logic [7:0] idx,
                                                        logic [15:0] delay,
                                                        logic [15:0] per,
                                                        logic handler);
        ptts_pkg::in_item_t c;
        c.command       = cmd;
        c.task_index    = idx;
        c.initial_delay = delay;
        c.period        = per;
        c.has_handler   = handler;
        return c;
    endfunction

    // mostly well-formed traffic on real slots with short delays and periods,
    // so tasks actually fall due; a minority of bad indices, null handlers,
    // wide counts and unknown codes as noise
    function automatic ptts_pkg::in_item_t random_command();
        ptts_pkg::in_item_t c;
        int                 roll;
        roll = $urandom_range(99);
        if (roll < 35)
            c.command = ptts_pkg::CMD_TICK;
        else if (roll < 55)
            c.command = ptts_pkg::CMD_DISPATCH;
        else if (roll < 73)
            c.command = ptts_pkg::CMD_CREATE;
        else if (roll < 83)
            c.command = ptts_pkg::CMD_STOP;
        else if (roll < 94)
            c.command = ptts_pkg::CMD_RESUME;
        else
            c.command = 3'($urandom_range(5, 7));
        c.task_index    = ($urandom_range(99) < 88) ? 8'($urandom_range(TASK_SLOTS - 1))
                                                    : 8'($urandom_range(255));
        c.initial_delay = ($urandom_range(99) < 85) ? 16'($urandom_range(6))
                                                    : 16'($urandom_range(65535));
        c.period        = ($urandom_range(99) < 85) ? 16'($urandom_range(6))
                                                    : 16'($urandom_range(65535));
        c.has_handler   = ($urandom_range(99) < 90);
        return c;
    endfunction

    // present one command and hold it until busy is low at a rising edge;
    // start stays high afterwards while a burst lasts, so it can continue without a gap
    task automatic send(input ptts_pkg::in_item_t cmd);
        int gap;
        start <= 1'b1;
        item  <= cmd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // bursty sender: a run of back-to-back transfers, then a random gap,
        // so gaps land on every phase of the slot sweep
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap)
                @(posedge clk);
            burst_left = ($urandom_range(5) == 0) ? $urandom_range(15, 30)
                                                  : $urandom_range(0, 6);
        end
    endtask

    initial
    begin
        // reset held low from the start, released once
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // dispatch on an empty table gives nothing
        send(pack_command(ptts_pkg::CMD_DISPATCH, 8'd0, 16'd0, 16'd0, 1'b0));
        // zero period on slot 0, due on the first tick
        send(pack_command(ptts_pkg::CMD_CREATE, 8'd0, 16'd0, 16'd0, 1'b1));
        // highest slot, short period
        send(pack_command(ptts_pkg::CMD_CREATE, 8'd7, 16'd1, 16'd1, 1'b1));
        // widest delay and period
        send(pack_command(ptts_pkg::CMD_CREATE, 8'd3, 16'hFFFF, 16'hFFFF, 1'b1));
        // create errors: index just out of range, top index, null handler
        send(pack_command(ptts_pkg::CMD_CREATE, 8'd8, 16'd2, 16'd2, 1'b1));
        send(pack_command(ptts_pkg::CMD_CREATE, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send(pack_command(ptts_pkg::CMD_CREATE, 8'd2, 16'd0, 16'd1, 1'b0));
        // first tick makes slot 0 pending and reloads it to all ones
        send(pack_command(ptts_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0, 1'b0));
        send(pack_command(ptts_pkg::CMD_DISPATCH, 8'd0, 16'd0, 16'd0, 1'b0));
        // stop a live slot, an unregistered slot and a wild index
        send(pack_command(ptts_pkg::CMD_STOP, 8'd7, 16'd0, 16'd0, 1'b0));
        send(pack_command(ptts_pkg::CMD_STOP, 8'd5, 16'd0, 16'd0, 1'b0));
        send(pack_command(ptts_pkg::CMD_STOP, 8'd200, 16'hFFFF, 16'hFFFF, 1'b1));
        send(pack_command(ptts_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0, 1'b0));
        send(pack_command(ptts_pkg::CMD_RESUME, 8'd7, 16'd0, 16'd0, 1'b0));
        send(pack_command(ptts_pkg::CMD_RESUME, 8'd6, 16'd0, 16'd0, 1'b0));
        send(pack_command(ptts_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0, 1'b0));
        send(pack_command(ptts_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0, 1'b0));
        // unknown codes are ignored
        send(pack_command(3'd5, 8'd1, 16'd1, 16'd1, 1'b1));
        send(pack_command(3'd6, 8'd0, 16'd0, 16'd0, 1'b0));
        send(pack_command(3'd7, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
        // fill the table with due-now tasks, then tick and dispatch all eight
        for (int s = 0; s < TASK_SLOTS; s++)
            send(pack_command(ptts_pkg::CMD_CREATE, 8'(s), 16'd0, 16'd3, 1'b1));
        send(pack_command(ptts_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0, 1'b0));
        // recreating a pending slot keeps its pending mark
        send(pack_command(ptts_pkg::CMD_CREATE, 8'd1, 16'd9, 16'd9, 1'b1));
        send(pack_command(ptts_pkg::CMD_DISPATCH, 8'd0, 16'd0, 16'd0, 1'b0));

        // random part
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send(random_command());

        // let every expected result arrive, then allow a full sweep more
        start <= 1'b0;
        while (results_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0 && results_owed == 0)
            $display("periodic_task_tick_scheduler_unit regression: pass");
        else
            $display("periodic_task_tick_scheduler_unit regression: fail");
        $finish;
    end

endmodule
